@@ design/bwtp_pkg.sv @@
// Package for the bus write timeline pacer: field widths, command and
// result codes, sequencer state type and fixed pacing constants.
// No dependencies.
`timescale 1ns / 1ps

package bwtp_pkg;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int ADDR_W  = 8;
    localparam int OADDR_W = 7;
    localparam int DATA_W  = 8;
    localparam int GAP_W   = 16;
    localparam int TIME_W  = 48;
    localparam int Q_W     = 32;
    localparam int COUNT_W = 41;
    localparam int KIND_W  = 2;

    // Product of due count and Q16 rate, due time, shared adder width
    localparam int MUL_W   = COUNT_W + Q_W;
    localparam int DUE_W   = MUL_W - 16 + 1;
    localparam int ADD_W   = MUL_W + 1;

    // Multiplier steps (one rate bit per cycle) and index width into the rate
    localparam int MUL_STEPS = Q_W;
    localparam int QIDX_W    = $clog2(Q_W);

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_US_PER_CYCLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PACING_EN    = 1'd1;

    // Configuration reset values
    localparam logic [Q_W-1:0] US_PER_CYCLE_RST = 32'd66517;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WAIT   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RESYNC = 2'd3;

    // Issue kinds
    localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DROPPED = 2'd3;

    // Pacing constants
    localparam logic [GAP_W-1:0]   PACED_GAP    = 16'd256;
    localparam logic [COUNT_W-1:0] DUE_LIMIT    = 41'h100_0000_0000;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 41'h1FF_FFFF_FFFF;
    localparam logic [TIME_W-1:0]  TIME_MAX     = 48'hFFFF_FFFF_FFFF;
    localparam logic [DATA_W-1:0]  DROPPED_DATA = 8'hFF;

    // Sequencer states, one-hot
    typedef enum logic [8:0] {
        ST_IDLE = 9'b0_0000_0001,
        ST_MUL  = 9'b0_0000_0010,
        ST_DUE  = 9'b0_0000_0100,
        ST_LAG  = 9'b0_0000_1000,
        ST_DIV  = 9'b0_0001_0000,
        ST_TRIM = 9'b0_0010_0000,
        ST_UPD  = 9'b0_0100_0000,
        ST_WCHK = 9'b0_1000_0000,
        ST_FIN  = 9'b1_0000_0000
    } t_state;

endpackage

@@ design/bus_write_timeline_pacer_core.sv @@
// Bus write timeline pacer core: sequencer around one shared wide adder.
// Depends on bwtp_pkg.
`timescale 1ns / 1ps

// Usage
//   Input channel (i_in_valid / o_in_ready) carries one bus request: command,
//   register address, write byte, cycle gap and the current microsecond time.
//   Output channel (o_out_valid / i_out_ready) returns one result per request.
//   Config port (i_cfg_we, i_cfg_index, i_cfg_data) sets the Q16 rate and the
//   pacing enable; write it only while no request is in flight.
// Operation
//   A request that only starts the timeline, a resync or a paced-off request
//   skips the due-time evaluation. Due-time evaluation steps one rate bit per
//   cycle through the shared adder, then does the origin add and the lag subtract;
//   the lag-to-cycles divide then gives one quotient bit per cycle. A late
//   request with a long gap evaluates the due time twice, around the divide.
//   One request is worked at a time.
// Reset and stall
//   Reset clears the timeline, restores the rate and pacing defaults and
//   drops any held result. A result waits in the output register while the
//   receiver stalls; the next request is taken meanwhile and is held at its
//   last step until the register frees.

module bus_write_timeline_pacer_core #(
    parameter int MAX_LAG_US = 250000
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [bwtp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bwtp_pkg::Q_W-1:0]          i_cfg_data,
    // request channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [bwtp_pkg::CMD_W-1:0]        i_cmd,
    input  logic [bwtp_pkg::ADDR_W-1:0]       i_reg_addr,
    input  logic [bwtp_pkg::DATA_W-1:0]       i_write_value,
    input  logic [bwtp_pkg::GAP_W-1:0]        i_gap_cycles,
    input  logic [bwtp_pkg::TIME_W-1:0]       i_now_us,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [bwtp_pkg::KIND_W-1:0]       o_issue_kind,
    output logic [bwtp_pkg::OADDR_W-1:0]      o_out_addr,
    output logic [bwtp_pkg::DATA_W-1:0]       o_out_value,
    output logic [bwtp_pkg::GAP_W-1:0]        o_bus_delay,
    output logic                              o_hold,
    output logic [bwtp_pkg::TIME_W-1:0]       o_hold_until_us,
    output logic                              o_late,
    output logic                              o_rebased
);

    localparam int ADD_W  = bwtp_pkg::ADD_W;
    localparam int MUL_W  = bwtp_pkg::MUL_W;
    localparam int DUE_W  = bwtp_pkg::DUE_W;
    localparam int Q_W    = bwtp_pkg::Q_W;
    localparam int GAP_W  = bwtp_pkg::GAP_W;
    localparam int TIME_W = bwtp_pkg::TIME_W;
    localparam int CNT_W_ = bwtp_pkg::COUNT_W;

    // Divider sizing follows from the lag bound
    localparam int LAG_W     = $clog2(MAX_LAG_US + 1);
    localparam int DIV_W     = LAG_W + 16;
    localparam int MAX_STEPS = (DIV_W > bwtp_pkg::MUL_STEPS) ? DIV_W : bwtp_pkg::MUL_STEPS;
    localparam int STEP_W    = $clog2(MAX_STEPS);
    localparam logic [ADD_W-1:0] MAX_LAG = ADD_W'(MAX_LAG_US);

    // Configuration
    logic [Q_W-1:0]            r_us_per_cycle;
    logic                      r_pacing_en;

    // Timeline state
    bwtp_pkg::t_state          r_state, n_state;
    logic                      r_started, n_started;
    logic [TIME_W-1:0]         r_origin, n_origin;
    logic [CNT_W_-1:0]         r_count, n_count;

    // Latched request
    logic [bwtp_pkg::CMD_W-1:0]  r_cmd, n_cmd;
    logic [bwtp_pkg::ADDR_W-1:0] r_addr, n_addr;
    logic [bwtp_pkg::DATA_W-1:0] r_val, n_val;
    logic [GAP_W-1:0]            r_gap, n_gap;
    logic [TIME_W-1:0]           r_now, n_now;

    // Working values and flags
    logic [GAP_W-1:0]          r_d, n_d;
    logic                      r_hold, n_hold;
    logic [TIME_W-1:0]         r_hold_until, n_hold_until;
    logic                      r_late, n_late;
    logic                      r_rebased, n_rebased;
    logic                      r_wphase, n_wphase;
    logic [MUL_W-1:0]          r_acc, n_acc;
    logic [DUE_W-1:0]          r_due, n_due;
    logic [Q_W-1:0]            r_rem, n_rem;
    logic [DIV_W-1:0]          r_dvq, n_dvq;
    logic [STEP_W-1:0]         r_step, n_step;

    // Output register
    logic                          r_out_valid, n_out_valid;
    logic [bwtp_pkg::KIND_W-1:0]   r_kind, n_kind;
    logic [bwtp_pkg::OADDR_W-1:0]  r_oaddr, n_oaddr;
    logic [bwtp_pkg::DATA_W-1:0]   r_oval, n_oval;
    logic [GAP_W-1:0]              r_odelay, n_odelay;
    logic                          r_ohold, n_ohold;
    logic [TIME_W-1:0]             r_ohold_until, n_ohold_until;
    logic                          r_olate, n_olate;
    logic                          r_orebased, n_orebased;

    // Shared adder
    logic [ADD_W-1:0]          add_a, add_b, add_sum;
    logic                      add_cin;
    logic [Q_W:0]              rem_sh;
    logic                      q_bit;
    logic                      rate_zero;
    logic                      in_acc;
    logic                      out_free;

    assign rate_zero = (r_us_per_cycle == '0);
    assign in_acc    = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;
    assign rem_sh    = {r_rem, r_dvq[DIV_W-1]};
    assign q_bit     = !add_sum[ADD_W-1];

    // Operand select for the one adder used by the multiply, due, lag, divide and update steps
    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
        unique case (r_state)
            bwtp_pkg::ST_MUL: begin
                add_a = ADD_W'({r_acc[MUL_W-2:0], 1'b0});
                add_b = r_us_per_cycle[r_step[bwtp_pkg::QIDX_W-1:0]] ?
                        ADD_W'(r_count) : '0;
            end
            bwtp_pkg::ST_DUE: begin
                add_a = ADD_W'(r_origin);
                add_b = ADD_W'(r_acc[MUL_W-1:16]);
            end
            bwtp_pkg::ST_LAG: begin
                add_a   = ADD_W'(r_now);
                add_b   = ~ADD_W'(r_due);
                add_cin = 1'b1;
            end
            bwtp_pkg::ST_DIV: begin
                add_a   = ADD_W'(rem_sh);
                add_b   = ~ADD_W'(r_us_per_cycle);
                add_cin = 1'b1;
            end
            bwtp_pkg::ST_UPD: begin
                add_a   = ADD_W'(r_count);
                add_b   = ADD_W'(r_gap);
                add_cin = (r_cmd != bwtp_pkg::CMD_WAIT);
            end
            bwtp_pkg::ST_IDLE, bwtp_pkg::ST_TRIM,
            bwtp_pkg::ST_WCHK, bwtp_pkg::ST_FIN: begin
                add_a = '0;
            end
            default: begin
                add_a = '0;
            end
        endcase
    end

    assign add_sum = add_a + add_b + ADD_W'(add_cin);

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_started    = r_started;
        n_origin     = r_origin;
        n_count      = r_count;
        n_cmd        = r_cmd;
        n_addr       = r_addr;
        n_val        = r_val;
        n_gap        = r_gap;
        n_now        = r_now;
        n_d          = r_d;
        n_hold       = r_hold;
        n_hold_until = r_hold_until;
        n_late       = r_late;
        n_rebased    = r_rebased;
        n_wphase     = r_wphase;
        n_acc        = r_acc;
        n_due        = r_due;
        n_rem        = r_rem;
        n_dvq        = r_dvq;
        n_step       = r_step;

        n_out_valid   = r_out_valid && !i_out_ready;
        n_kind        = r_kind;
        n_oaddr       = r_oaddr;
        n_oval        = r_oval;
        n_odelay      = r_odelay;
        n_ohold       = r_ohold;
        n_ohold_until = r_ohold_until;
        n_olate       = r_olate;
        n_orebased    = r_orebased;

        unique case (r_state)
            bwtp_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_cmd        = i_cmd;
                    n_addr       = i_reg_addr;
                    n_val        = i_write_value;
                    n_gap        = i_gap_cycles;
                    n_now        = i_now_us;
                    n_d          = i_gap_cycles;
                    n_hold       = 1'b0;
                    n_hold_until = '0;
                    n_late       = 1'b0;
                    n_rebased    = 1'b0;
                    n_wphase     = 1'b0;
                    n_acc        = '0;
                    n_step       = STEP_W'(bwtp_pkg::MUL_STEPS - 1);
                    priority if (i_cmd == bwtp_pkg::CMD_RESYNC) begin
                        n_started = 1'b0;
                        n_state   = bwtp_pkg::ST_FIN;
                    end else if (i_cmd == bwtp_pkg::CMD_WAIT && rate_zero) begin
                        n_state = bwtp_pkg::ST_FIN;
                    end else if (!r_started) begin
                        // first request starts the timeline only
                        n_started = 1'b1;
                        n_origin  = i_now_us;
                        n_count   = '0;
                        n_state   = bwtp_pkg::ST_FIN;
                    end else if (i_cmd == bwtp_pkg::CMD_WAIT) begin
                        n_state = bwtp_pkg::ST_UPD;
                    end else if (i_gap_cycles != '0 && r_pacing_en && !rate_zero) begin
                        n_state = bwtp_pkg::ST_MUL;
                    end else begin
                        n_state = bwtp_pkg::ST_UPD;
                    end
                end
            end

            // count * rate, one rate bit per cycle from the top
            bwtp_pkg::ST_MUL: begin
                n_acc = add_sum[MUL_W-1:0];
                if (r_step == '0) begin
                    n_state = bwtp_pkg::ST_DUE;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end

            // due = origin + (count * rate) >> 16
            bwtp_pkg::ST_DUE: begin
                n_due   = add_sum[DUE_W-1:0];
                n_state = bwtp_pkg::ST_LAG;
            end

            // now - due, sign gives early or late
            bwtp_pkg::ST_LAG: begin
                if (!r_wphase) begin
                    n_state = bwtp_pkg::ST_UPD;
                    if (!add_sum[ADD_W-1] && add_sum != '0) begin
                        if (add_sum > MAX_LAG) begin
                            n_origin  = r_now;
                            n_count   = '0;
                            n_rebased = 1'b1;
                        end else begin
                            n_late  = 1'b1;
                            n_rem   = '0;
                            n_dvq   = {add_sum[LAG_W-1:0], 16'd0};
                            n_step  = STEP_W'(DIV_W - 1);
                            n_state = bwtp_pkg::ST_DIV;
                        end
                    end
                end else begin
                    n_state = bwtp_pkg::ST_FIN;
                    if (add_sum[ADD_W-1]) begin
                        n_hold       = 1'b1;
                        n_hold_until = (r_due > DUE_W'(bwtp_pkg::TIME_MAX)) ?
                                       bwtp_pkg::TIME_MAX : r_due[TIME_W-1:0];
                    end else if (add_sum > MAX_LAG) begin
                        n_origin  = r_now;
                        n_count   = '0;
                        n_rebased = 1'b1;
                    end
                end
            end

            // restoring divide: (lag << 16) / rate, one quotient bit per cycle
            bwtp_pkg::ST_DIV: begin
                n_rem = q_bit ? add_sum[Q_W-1:0] : rem_sh[Q_W-1:0];
                n_dvq = {r_dvq[DIV_W-2:0], q_bit};
                if (r_step == '0) begin
                    n_state = bwtp_pkg::ST_TRIM;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end

            // delay shrinks by the lag in cycles, floored at zero
            bwtp_pkg::ST_TRIM: begin
                n_d     = (r_dvq >= DIV_W'(r_d)) ? '0 : (r_d - r_dvq[GAP_W-1:0]);
                n_state = bwtp_pkg::ST_UPD;
            end

            // count grows by the gap (plus one for a bus access), saturating
            bwtp_pkg::ST_UPD: begin
                n_count = (add_sum > ADD_W'(bwtp_pkg::COUNT_MAX)) ?
                          bwtp_pkg::COUNT_MAX : add_sum[CNT_W_-1:0];
                if (r_cmd == bwtp_pkg::CMD_WAIT) begin
                    n_state = bwtp_pkg::ST_WCHK;
                end else if (r_gap > bwtp_pkg::PACED_GAP && !rate_zero) begin
                    n_d     = '0;
                    n_state = bwtp_pkg::ST_WCHK;
                end else begin
                    n_state = bwtp_pkg::ST_FIN;
                end
            end

            // wait step: pacing off finishes, oversized count rebases, else evaluate due time
            bwtp_pkg::ST_WCHK: begin
                if (!r_pacing_en) begin
                    n_state = bwtp_pkg::ST_FIN;
                end else if (r_count > bwtp_pkg::DUE_LIMIT) begin
                    n_origin  = r_now;
                    n_count   = '0;
                    n_rebased = 1'b1;
                    n_state   = bwtp_pkg::ST_FIN;
                end else begin
                    n_wphase = 1'b1;
                    n_acc    = '0;
                    n_step   = STEP_W'(bwtp_pkg::MUL_STEPS - 1);
                    n_state  = bwtp_pkg::ST_MUL;
                end
            end

            // load the result once the output register is free
            bwtp_pkg::ST_FIN: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_kind        = bwtp_pkg::KIND_NONE;
                    n_oaddr       = '0;
                    n_oval        = '0;
                    n_odelay      = '0;
                    n_ohold       = r_hold;
                    n_ohold_until = r_hold_until;
                    n_olate       = r_late;
                    n_orebased    = r_rebased;
                    if (r_cmd == bwtp_pkg::CMD_WRITE || r_cmd == bwtp_pkg::CMD_READ) begin
                        if (!r_addr[bwtp_pkg::ADDR_W-1]) begin
                            n_kind   = (r_cmd == bwtp_pkg::CMD_WRITE) ?
                                       bwtp_pkg::KIND_WRITE : bwtp_pkg::KIND_READ;
                            n_oaddr  = r_addr[bwtp_pkg::OADDR_W-1:0];
                            n_oval   = (r_cmd == bwtp_pkg::CMD_WRITE) ? r_val : '0;
                            n_odelay = r_d;
                        end else if (r_cmd == bwtp_pkg::CMD_READ) begin
                            n_kind = bwtp_pkg::KIND_DROPPED;
                            n_oval = bwtp_pkg::DROPPED_DATA;
                        end
                    end
                    n_state = bwtp_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = bwtp_pkg::ST_IDLE;
            end
        endcase
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= bwtp_pkg::ST_IDLE;
            r_started      <= 1'b0;
            r_origin       <= '0;
            r_count        <= '0;
            r_out_valid    <= 1'b0;
            r_us_per_cycle <= bwtp_pkg::US_PER_CYCLE_RST;
            r_pacing_en    <= 1'b1;
        end else begin
            r_state     <= n_state;
            r_started   <= n_started;
            r_origin    <= n_origin;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    bwtp_pkg::CFG_US_PER_CYCLE: r_us_per_cycle <= i_cfg_data;
                    bwtp_pkg::CFG_PACING_EN:    r_pacing_en    <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // Payload and working registers
    always_ff @(posedge i_clk) begin
        r_cmd         <= n_cmd;
        r_addr        <= n_addr;
        r_val         <= n_val;
        r_gap         <= n_gap;
        r_now         <= n_now;
        r_d           <= n_d;
        r_hold        <= n_hold;
        r_hold_until  <= n_hold_until;
        r_late        <= n_late;
        r_rebased     <= n_rebased;
        r_wphase      <= n_wphase;
        r_acc         <= n_acc;
        r_due         <= n_due;
        r_rem         <= n_rem;
        r_dvq         <= n_dvq;
        r_step        <= n_step;
        r_kind        <= n_kind;
        r_oaddr       <= n_oaddr;
        r_oval        <= n_oval;
        r_odelay      <= n_odelay;
        r_ohold       <= n_ohold;
        r_ohold_until <= n_ohold_until;
        r_olate       <= n_olate;
        r_orebased    <= n_orebased;
    end

    // Ports
    assign o_in_ready      = (r_state == bwtp_pkg::ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_issue_kind    = r_kind;
    assign o_out_addr      = r_oaddr;
    assign o_out_value     = r_oval;
    assign o_bus_delay     = r_odelay;
    assign o_hold          = r_ohold;
    assign o_hold_until_us = r_ohold_until;
    assign o_late          = r_olate;
    assign o_rebased       = r_orebased;

endmodule
